// ----- hdl/stt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // input request: one source byte or the end-of-source mark
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } t_stt_in;

    // one result item
    typedef struct packed {
        logic [2:0] token_type;
        logic       has_char;
        logic [7:0] char_out;
        logic       token_end;
        logic       last_of_step;
    } t_stt_result;

    // what one request produces: zero to two results, in order
    typedef struct packed {
        logic [1:0]  count;
        t_stt_result first;
        t_stt_result second;
    } t_stt_emit;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_WORD    = 3'd3,
        MODE_NUMBER  = 3'd4,
        MODE_STRING  = 3'd5
    } t_stt_mode;

    localparam logic [2:0] TT_KEYWORD = 3'd0;
    localparam logic [2:0] TT_IDENT   = 3'd1;
    localparam logic [2:0] TT_NUMBER  = 3'd2;
    localparam logic [2:0] TT_STRING  = 3'd3;
    localparam logic [2:0] TT_OPER    = 3'd4;
    localparam logic [2:0] TT_SYMBOL  = 3'd5;
    localparam logic [2:0] TT_INVALID = 3'd6;
    localparam logic [2:0] TT_EOF     = 3'd7;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [2:0] KW_INT_LEN    = 3'd3;
    localparam logic [2:0] KW_STRING_LEN = 3'd6;
    localparam logic [2:0] KW_RETURN_LEN = 3'd6;
    localparam logic [2:0] WLEN_MAX      = 3'd7;
    localparam logic [2:0] KW_ALL        = 3'b111;

    // output queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_CNT_W = 3;
    localparam logic [Q_CNT_W-1:0] Q_ROOM_LIMIT = 3'd2;

    function automatic logic stt_is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic stt_is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic stt_is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // keyword spellings: 0 int, 1 string, 2 return
    function automatic logic [7:0] stt_kw_byte(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (k)
            2'd0: begin
                case (idx)
                    3'd0: b = 8'h69; // i
                    3'd1: b = 8'h6E; // n
                    3'd2: b = 8'h74; // t
                    default: b = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0: b = 8'h73; // s
                    3'd1: b = 8'h74; // t
                    3'd2: b = 8'h72; // r
                    3'd3: b = 8'h69; // i
                    3'd4: b = 8'h6E; // n
                    3'd5: b = 8'h67; // g
                    default: b = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    3'd0: b = 8'h72; // r
                    3'd1: b = 8'h65; // e
                    3'd2: b = 8'h74; // t
                    3'd3: b = 8'h75; // u
                    3'd4: b = 8'h72; // r
                    3'd5: b = 8'h6E; // n
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // narrow the keyword candidates by one more byte of the word
    function automatic logic [2:0] stt_kw_step(input logic [2:0] cand,
                                               input logic [2:0] wlen,
                                               input logic [7:0] c);
        logic [2:0] nc;
        nc[0] = cand[0] && (wlen < KW_INT_LEN)    && (stt_kw_byte(2'd0, wlen) == c);
        nc[1] = cand[1] && (wlen < KW_STRING_LEN) && (stt_kw_byte(2'd1, wlen) == c);
        nc[2] = cand[2] && (wlen < KW_RETURN_LEN) && (stt_kw_byte(2'd2, wlen) == c);
        return nc;
    endfunction

    function automatic logic stt_kw_hit(input logic [2:0] cand, input logic [2:0] wlen);
        return (cand[0] && wlen == KW_INT_LEN) || (cand[1] && wlen == KW_STRING_LEN) ||
               (cand[2] && wlen == KW_RETURN_LEN);
    endfunction

    function automatic t_stt_result stt_mk(input logic [2:0] tt, input logic has,
                                           input logic [7:0] ch, input logic tend);
        t_stt_result r;
        r.token_type   = tt;
        r.has_char     = has;
        r.char_out     = has ? ch : 8'h00;
        r.token_end    = tend;
        r.last_of_step = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stt_lexer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lexer state and the per-request decode; state moves only on i_adv.
module stt_lexer_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire stt_pkg::t_stt_in   i_item,
    output stt_pkg::t_stt_emit  o_emit
);
    import stt_pkg::*;

    t_stt_mode  r_mode, n_mode;
    logic [2:0] r_wlen, n_wlen;
    logic [2:0] r_cand, n_cand;

    logic        pre_v, main_v;
    t_stt_result pre_r, main_r;
    logic [7:0]  c;
    logic        start;

    always_comb begin
        c      = i_item.char_code;
        n_mode = r_mode;
        n_wlen = r_wlen;
        n_cand = r_cand;
        pre_v  = 1'b0;
        pre_r  = '0;
        main_v = 1'b0;
        main_r = '0;
        start  = 1'b0;

        if (i_item.end_of_source) begin
            case (r_mode)
                MODE_WORD: begin
                    pre_v = 1'b1;
                    pre_r = stt_mk(stt_kw_hit(r_cand, r_wlen) ? TT_KEYWORD : TT_IDENT,
                                   1'b0, 8'h00, 1'b1);
                end
                MODE_NUMBER: begin
                    pre_v = 1'b1;
                    pre_r = stt_mk(TT_NUMBER, 1'b0, 8'h00, 1'b1);
                end
                MODE_STRING: begin
                    pre_v = 1'b1;
                    pre_r = stt_mk(TT_STRING, 1'b0, 8'h00, 1'b1);
                end
                MODE_SLASH: begin
                    pre_v = 1'b1;
                    pre_r = stt_mk(TT_INVALID, 1'b1, CH_SLASH, 1'b1);
                end
                default: pre_v = 1'b0;
            endcase
            main_v = 1'b1;
            main_r = stt_mk(TT_EOF, 1'b0, 8'h00, 1'b1);
            n_mode = MODE_IDLE;
            n_wlen = 3'd0;
            n_cand = KW_ALL;
        end else begin
            case (r_mode)
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) n_mode = MODE_IDLE;
                end
                MODE_STRING: begin
                    main_v = 1'b1;
                    if (c == CH_QUOTE) begin
                        main_r = stt_mk(TT_STRING, 1'b0, 8'h00, 1'b1);
                        n_mode = MODE_IDLE;
                    end else begin
                        main_r = stt_mk(TT_STRING, 1'b1, c, 1'b0);
                    end
                end
                MODE_WORD: begin
                    if (stt_is_alpha(c) || stt_is_digit(c)) begin
                        main_v = 1'b1;
                        main_r = stt_mk(TT_IDENT, 1'b1, c, 1'b0);
                        n_cand = stt_kw_step(r_cand, r_wlen, c);
                        n_wlen = (r_wlen < WLEN_MAX) ? r_wlen + 3'd1 : r_wlen;
                    end else begin
                        pre_v = 1'b1;
                        pre_r = stt_mk(stt_kw_hit(r_cand, r_wlen) ? TT_KEYWORD : TT_IDENT,
                                       1'b0, 8'h00, 1'b1);
                        start = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (stt_is_digit(c)) begin
                        main_v = 1'b1;
                        main_r = stt_mk(TT_NUMBER, 1'b1, c, 1'b0);
                    end else begin
                        pre_v = 1'b1;
                        pre_r = stt_mk(TT_NUMBER, 1'b0, 8'h00, 1'b1);
                        start = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        pre_v = 1'b1;
                        pre_r = stt_mk(TT_INVALID, 1'b1, CH_SLASH, 1'b1);
                        start = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase

            // byte seen as if idle
            if (start) begin
                n_mode = MODE_IDLE;
                if (stt_is_space(c)) begin
                    main_v = 1'b0;
                end else if (c == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else if (stt_is_alpha(c)) begin
                    n_mode = MODE_WORD;
                    n_wlen = 3'd1;
                    n_cand = stt_kw_step(KW_ALL, 3'd0, c);
                    main_v = 1'b1;
                    main_r = stt_mk(TT_IDENT, 1'b1, c, 1'b0);
                end else if (stt_is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    main_v = 1'b1;
                    main_r = stt_mk(TT_NUMBER, 1'b1, c, 1'b0);
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                end else if (c == CH_PLUS || c == CH_MINUS || c == CH_EQUALS ||
                             c == CH_SEMI) begin
                    main_v = 1'b1;
                    main_r = stt_mk(TT_OPER, 1'b1, c, 1'b1);
                end else if (c == CH_LBRACE || c == CH_RBRACE) begin
                    main_v = 1'b1;
                    main_r = stt_mk(TT_SYMBOL, 1'b1, c, 1'b1);
                end else begin
                    main_v = 1'b1;
                    main_r = stt_mk(TT_INVALID, 1'b1, c, 1'b1);
                end
            end
        end

        // pack in order, flag the last one
        o_emit = '0;
        if (pre_v) begin
            o_emit.first  = pre_r;
            o_emit.second = main_r;
            o_emit.count  = main_v ? 2'd2 : 2'd1;
            if (main_v) o_emit.second.last_of_step = 1'b1;
            else        o_emit.first.last_of_step  = 1'b1;
        end else begin
            o_emit.first  = main_r;
            o_emit.count  = main_v ? 2'd1 : 2'd0;
            o_emit.first.last_of_step = main_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_wlen <= 3'd0;
            r_cand <= KW_ALL;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_wlen <= n_wlen;
            r_cand <= n_cand;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stt_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Four-slot shifting result queue; head is always slot 0.
module stt_out_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire stt_pkg::t_stt_emit           i_emit,
    input  wire logic                         i_pop,
    output stt_pkg::t_stt_result              o_head,
    output logic                              o_valid,
    output logic [stt_pkg::Q_CNT_W-1:0]       o_count
);
    import stt_pkg::*;

    t_stt_result         r_q [Q_DEPTH];
    t_stt_result         n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic [Q_CNT_W-1:0]  base;
    logic [1:0]          push_n;

    always_comb begin
        push_n = i_push ? i_emit.count : 2'd0;
        base   = r_cnt - {{(Q_CNT_W-1){1'b0}}, i_pop};
        for (int i = 0; i < Q_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (i_pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (push_n != 2'd0 && base == Q_CNT_W'(i)) n_q[i] = i_emit.first;
            if (push_n == 2'd2 && base + Q_CNT_W'(1) == Q_CNT_W'(i)) n_q[i] = i_emit.second;
        end
        n_cnt = base + {{(Q_CNT_W-2){1'b0}}, push_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_head  = r_q[0];
    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// ----- hdl/source_text_tokenizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// source    in         i_src_valid / o_src_ready   i_src_item (t_stt_in)
// token     out        o_tok_valid / i_tok_ready   o_tok      (t_stt_result)
//
// One request per clock while the sink is ready and each request gives at most one
// result; a request that gives two uses two output slots, so the sink's pace of one
// result a cycle sets the rate. A result passes through the input register and then
// the four-slot output queue. Synchronous active-low reset returns the lexer to idle
// and empties both stages. The input register advances only while the queue has room
// for two more results; o_src_ready stays high while that register can drain.
module source_text_tokenizer_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_src_valid,
    output logic                      o_src_ready,
    input  wire stt_pkg::t_stt_in     i_src_item,
    output logic                      o_tok_valid,
    input  wire logic                 i_tok_ready,
    output stt_pkg::t_stt_result      o_tok
);
    import stt_pkg::*;

    // input register
    logic     r_in_valid;
    t_stt_in  r_in;

    logic               adv;
    logic               pop;
    t_stt_emit          emit;
    logic [Q_CNT_W-1:0] q_count;

    // decode the held request once the queue can take both possible results
    assign adv         = r_in_valid && (q_count <= Q_ROOM_LIMIT);
    assign o_src_ready = !r_in_valid || adv;
    assign pop         = o_tok_valid && i_tok_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_src_ready) begin
            r_in_valid <= i_src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_src_ready && i_src_valid) begin
            r_in <= i_src_item;
        end
    end

    // mode, word length and keyword match live here
    stt_lexer_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_emit  (emit)
    );

    // results wait here until the sink takes them
    stt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_emit  (emit),
        .i_pop   (pop),
        .o_head  (o_tok),
        .o_valid (o_tok_valid),
        .o_count (q_count)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Tokeniser bench: source requests go in one byte at a time, tokens come out
// as a stream of result items. A local copy of the lexer predicts every result
// when a request is accepted; the token monitor pops the oldest prediction
// and compares it field by field.
module tb;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 50;

    // whitespace bounds not in the package
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    t_stt_in     src_item = '0;
    logic        tok_ready = 1'b0;
    logic        o_src_ready;
    logic        o_tok_valid;
    t_stt_result o_tok;

    // idling knobs, percent of cycles
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    int err_count = 0;
    int sent_count = 0;
    int tok_seen = 0;
    int cycle_count = 0;

    // expected token results, oldest first
    t_stt_result pending_tokens[$];

    // lexer state mirrored by the predictor
    t_stt_mode   lex_mode = MODE_IDLE;
    logic [2:0]  word_len = '0;
    logic [2:0]  kw_live  = KW_ALL;

    always #5 i_clk = ~i_clk;

    source_text_tokenizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_src_valid (src_valid),
        .o_src_ready (o_src_ready),
        .i_src_item  (src_item),
        .o_tok_valid (o_tok_valid),
        .i_tok_ready (tok_ready),
        .o_tok       (o_tok)
    );

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    function automatic string kw_spelling(input int k);
        case (k)
            0:       return "int";
            1:       return "string";
            default: return "return";
        endcase
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void push_token(input logic [2:0] tt, input logic has,
                                       input logic [7:0] ch, input logic tend);
        t_stt_result r;
        r.token_type   = tt;
        r.has_char     = has;
        r.char_out     = has ? ch : 8'h00;
        r.token_end    = tend;
        r.last_of_step = 1'b0;
        pending_tokens.push_back(r);
    endfunction

    // one more byte of a word: drop keywords that no longer match at this offset
    function automatic void take_word_byte(input logic [7:0] c);
        string kw;
        for (int k = 0; k < 3; k++) begin
            kw = kw_spelling(k);
            if (word_len >= kw.len() || kw[word_len] != c)
                kw_live[k] = 1'b0;
        end
        if (word_len != WLEN_MAX)
            word_len = word_len + 3'd1;
        push_token(TT_IDENT, 1'b1, c, 1'b0);
    endfunction

    // closing item: keyword only if a surviving candidate has exactly this length
    function automatic void close_word_token();
        logic [2:0] tt;
        string kw;
        tt = TT_IDENT;
        for (int k = 0; k < 3; k++) begin
            kw = kw_spelling(k);
            if (kw_live[k] && word_len == kw.len())
                tt = TT_KEYWORD;
        end
        push_token(tt, 1'b0, 8'h00, 1'b1);
    endfunction

    // a byte seen with no token open
    function automatic void open_from_idle(input logic [7:0] c);
        lex_mode = MODE_IDLE;
        if (is_blank(c))
            return;
        if (c == CH_SLASH) begin
            lex_mode = MODE_SLASH;
        end else if (is_letter(c)) begin
            lex_mode = MODE_WORD;
            word_len = '0;
            kw_live  = KW_ALL;
            take_word_byte(c);
        end else if (is_num(c)) begin
            lex_mode = MODE_NUMBER;
            push_token(TT_NUMBER, 1'b1, c, 1'b0);
        end else if (c == CH_QUOTE) begin
            lex_mode = MODE_STRING;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_EQUALS || c == CH_SEMI) begin
            push_token(TT_OPER, 1'b1, c, 1'b1);
        end else if (c == CH_LBRACE || c == CH_RBRACE) begin
            push_token(TT_SYMBOL, 1'b1, c, 1'b1);
        end else begin
            push_token(TT_INVALID, 1'b1, c, 1'b1);
        end
    endfunction

    // works out every result of one accepted request
    function automatic void tokenise_request(input t_stt_in req);
        int          base;
        t_stt_result tail;
        logic [7:0]  c;
        base = pending_tokens.size();
        c    = req.char_code;
        if (req.end_of_source) begin
            case (lex_mode)
                MODE_WORD:   close_word_token();
                MODE_NUMBER: push_token(TT_NUMBER, 1'b0, 8'h00, 1'b1);
                MODE_STRING: push_token(TT_STRING, 1'b0, 8'h00, 1'b1);
                MODE_SLASH:  push_token(TT_INVALID, 1'b1, CH_SLASH, 1'b1);
                default: ;
            endcase
            push_token(TT_EOF, 1'b0, 8'h00, 1'b1);
            lex_mode = MODE_IDLE;
            word_len = '0;
            kw_live  = KW_ALL;
        end else begin
            case (lex_mode)
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE)
                        lex_mode = MODE_IDLE;
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        push_token(TT_STRING, 1'b0, 8'h00, 1'b1);
                        lex_mode = MODE_IDLE;
                    end else begin
                        push_token(TT_STRING, 1'b1, c, 1'b0);
                    end
                end
                MODE_WORD: begin
                    if (is_letter(c) || is_num(c)) begin
                        take_word_byte(c);
                    end else begin
                        close_word_token();
                        open_from_idle(c);
                    end
                end
                MODE_NUMBER: begin
                    if (is_num(c)) begin
                        push_token(TT_NUMBER, 1'b1, c, 1'b0);
                    end else begin
                        push_token(TT_NUMBER, 1'b0, 8'h00, 1'b1);
                        open_from_idle(c);
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        lex_mode = MODE_COMMENT;
                    end else begin
                        push_token(TT_INVALID, 1'b1, CH_SLASH, 1'b1);
                        open_from_idle(c);
                    end
                end
                default: open_from_idle(c);
            endcase
        end
        // flag the final result of this request
        if (pending_tokens.size() > base) begin
            tail = pending_tokens.pop_back();
            tail.last_of_step = 1'b1;
            pending_tokens.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_token(input t_stt_result got);
        t_stt_result want;
        if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("token %0d arrived with nothing expected (type %0d)",
                                      tok_seen, got.token_type));
        end else begin
            want = pending_tokens.pop_front();
            if (got.token_type !== want.token_type)
                report_mismatch($sformatf("token %0d token_type %0d, expected %0d",
                                          tok_seen, got.token_type, want.token_type));
            if (got.has_char !== want.has_char)
                report_mismatch($sformatf("token %0d has_char %0b, expected %0b",
                                          tok_seen, got.has_char, want.has_char));
            if (got.char_out !== want.char_out)
                report_mismatch($sformatf("token %0d char_out %02h, expected %02h",
                                          tok_seen, got.char_out, want.char_out));
            if (got.token_end !== want.token_end)
                report_mismatch($sformatf("token %0d token_end %0b, expected %0b",
                                          tok_seen, got.token_end, want.token_end));
            if (got.last_of_step !== want.last_of_step)
                report_mismatch($sformatf("token %0d last_of_step %0b, expected %0b",
                                          tok_seen, got.last_of_step, want.last_of_step));
        end
        tok_seen++;
    endtask

    // Request and token monitor. Both handshakes are sampled with the values
    // they held just before the edge; prediction runs first, though a result
    // can never leave in the same cycle as its own request.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (src_valid && o_src_ready)
                tokenise_request(src_item);
            if (o_tok_valid && tok_ready)
                check_token(o_tok);
        end
    end

    // sink side: stall at the current rate, redrawn every cycle
    always @(posedge i_clk) begin
        tok_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Offers one request, idling first at the source rate. Valid stays high
    // into the next call so back-to-back requests never drop it.
    task automatic send_req(input t_stt_in req);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge i_clk);
        end
        src_valid <= 1'b1;
        src_item  <= req;
        @(posedge i_clk);
        while (!o_src_ready)
            @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        t_stt_in r;
        r.char_code     = c;
        r.end_of_source = 1'b0;
        send_req(r);
    endtask

    // end of source; the byte rides along and must be ignored
    task automatic send_eos(input logic [7:0] c);
        t_stt_in r;
        r.char_code     = c;
        r.end_of_source = 1'b1;
        send_req(r);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // holds the source off until every predicted token has been seen
    task automatic wait_for_drain();
        src_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random source text
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1))
            return 8'(8'h41 + $urandom_range(25));
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(3) == 0)
            return 8'(8'h30 + $urandom_range(9));
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(5);
        if (r == 5)
            return CH_SPACE;
        return 8'(CH_TAB + r);
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_EQUALS;
            3:       return CH_SEMI;
            4:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // keywords exact, cut short or overrun, plus plain identifiers
    task automatic send_word();
        string kw;
        int    n;
        if ($urandom_range(1)) begin
            kw = kw_spelling($urandom_range(2));
            case ($urandom_range(2))
                0: send_text(kw);
                1: begin
                    n = $urandom_range(kw.len() - 1, 1);
                    for (int i = 0; i < n; i++)
                        send_byte(kw[i]);
                end
                default: begin
                    send_text(kw);
                    n = $urandom_range(2, 1);
                    repeat (n) send_byte(rand_alnum());
                end
            endcase
        end else begin
            send_byte(rand_letter());
            // now and then long enough to saturate the length count
            n = ($urandom_range(4) == 0) ? $urandom_range(9, 6) : $urandom_range(4);
            repeat (n) send_byte(rand_alnum());
        end
    endtask

    task automatic send_number();
        int n;
        n = $urandom_range(5, 1);
        repeat (n) send_byte(8'(8'h30 + $urandom_range(9)));
    endtask

    // quoted text; occasionally left open for a later quote or end of source
    task automatic send_string_lit();
        int         n;
        logic [7:0] b;
        n = $urandom_range(6);
        send_byte(CH_QUOTE);
        repeat (n) begin
            if ($urandom_range(1)) begin
                b = rand_alnum();
            end else begin
                do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
            end
            send_byte(b);
        end
        if ($urandom_range(9) != 0)
            send_byte(CH_QUOTE);
    endtask

    task automatic send_comment();
        int         n;
        logic [7:0] b;
        n = $urandom_range(5);
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        repeat (n) begin
            do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
            send_byte(b);
        end
        send_byte(CH_NEWLINE);
    endtask

    // Mostly well-formed token runs with random content; the rest is raw
    // bytes, lone slashes, open strings and stray ends of source.
    task automatic send_random_source(input int n_items);
        int target;
        int pick;
        target = sent_count + n_items;
        while (sent_count < target) begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_byte(8'($urandom_range(255)));
            else if (pick < 13)
                send_eos(8'($urandom_range(255)));
            else if (pick < 36)
                send_word();
            else if (pick < 48)
                send_number();
            else if (pick < 58)
                send_string_lit();
            else if (pick < 66)
                send_comment();
            else if (pick < 82)
                send_byte(rand_punct());
            else if (pick < 86)
                send_byte(CH_SLASH);
            else
                send_byte(rand_blank());
            if ($urandom_range(1))
                send_byte(rand_blank());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_tokens();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_text("int");          // keyword...
        send_byte(8'hFF);          // ...closed by a high-bit byte, itself invalid
        send_byte("7");
        send_byte(8'h80);          // high-bit byte ends a number too
        send_text("\"\"");         // empty string still closes
        send_text("+{");
        send_text("/a//");         // slash released as invalid; word closed by a comment
        send_byte(CH_NEWLINE);     // ends the comment
        send_byte(CH_CR);          // whitespace skipped
        send_byte(8'h00);          // lowest byte, invalid
        send_text("\"s");
        send_eos(8'hFF);           // open string closed, byte ignored
        send_byte(CH_SLASH);
        send_eos(8'h00);           // held slash released at end of source
        send_byte("9");
        send_eos(8'h00);
        send_text("//");
        send_eos(8'h00);           // open comment dropped
        send_eos(8'h00);           // end of source with nothing open
        send_byte("x");
        send_eos(8'h00);           // open word closed
        wait_for_drain();
    endtask

    task automatic test_stream_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random_source(170);
        wait_for_drain();
    endtask

    task automatic test_stream_sparse_source();
        src_idle_pct   = 80;
        sink_stall_pct = 0;
        send_random_source(140);
        wait_for_drain();
    endtask

    task automatic test_stream_stalled_sink();
        src_idle_pct   = 0;
        sink_stall_pct = 80;
        send_random_source(140);
        wait_for_drain();
    endtask

    task automatic test_stream_both_idle();
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        send_random_source(140);
        wait_for_drain();
    endtask

    // source paused mid-stream until the output side has fully emptied
    task automatic test_pause_until_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 50;
        send_random_source(40);
        wait_for_drain();
        repeat (5) @(posedge i_clk);
        send_random_source(40);
        wait_for_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed_tokens();
        test_stream_no_idle();
        test_stream_sparse_source();
        test_stream_stalled_sink();
        test_stream_both_idle();
        test_pause_until_drained();
        wait_for_drain();
        // room for any stray token behind the two-stage pipe
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- source_text_tokenizer_unit.f -----
hdl/stt_pkg.sv
hdl/stt_lexer_core.sv
hdl/stt_out_queue.sv
hdl/source_text_tokenizer_unit.sv
test/tb.sv
